// ----- rtl/cvp_pkg.sv -----
package cvp_pkg;

    localparam int NUM_CH          = 16;
    localparam int LP_W            = 20;
    localparam int NUM_CHORDS_DFLT = 11;

    localparam logic [3:0] CH_LAST      = 4'd15;
    localparam logic [3:0] CH_ATT_FIRST = 4'd11;
    localparam logic [3:0] CH_ATT_FREQ  = 4'd11;

    localparam logic [16:0] CHORD_OFFSET_RST = 17'd33095;

    // floor(n / 10) = (n * LAW_RECIP) >> 26 for n below 2^23
    localparam logic [22:0] LAW_RECIP  = 23'd6710887;
    // floor(e / 50) = (e * FM_RECIP) >> 24 for e below the jump threshold
    localparam logic [18:0] FM_RECIP   = 19'd335545;
    // floor(m / 10) = (m * TEN_RECIP) >> 14 for m below 2730
    localparam logic [10:0] TEN_RECIP  = 11'd1639;
    localparam logic [22:0] FM_JUMP    = 23'd52429;
    localparam logic [16:0] STRUCT_MAX = 17'd65503;
    localparam logic [16:0] Q_ONE      = 17'd65536;
    localparam logic signed [26:0] FM_LIMIT = 27'sd3145728;

    typedef struct packed {
        logic load;
        logic law1;
        logic law2;
        logic law3;
        logic law4;
        logic filt1;
        logic filt2;
        logic frm1;
        logic frm2;
        logic frm3;
        logic frm4;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } sts_t;

    // lowpass divisor 1 skips the reciprocal multiply
    function automatic logic lp_unity(input logic [3:0] ch);
        logic u;
        case (ch)
            4'd0:    u = 1'b1;
            4'd5:    u = 1'b1;
            default: u = 1'b0;
        endcase
        return u;
    endfunction

    // ceil(2^32 / divisor) of each channel's lowpass
    function automatic logic [28:0] lp_recip(input logic [3:0] ch);
        logic [28:0] m;
        case (ch)
            4'd1, 4'd2:                      m = 29'd429496730;
            4'd3:                            m = 29'd214748365;
            4'd4, 4'd6, 4'd7, 4'd8, 4'd9,
            4'd10:                           m = 29'd42949673;
            4'd11, 4'd12, 4'd13, 4'd14,
            4'd15:                           m = 29'd21474837;
            default:                         m = 29'd0;
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/cv_pot_conditioner.sv -----
// Control-rate conditioner for a 16-channel frame of CVs, pots and attenuverters.
// Each input transaction carries one channel's converter sample; the channel is
// shaped (attenuverters only) and lowpassed by the shared law and filter datapath
// stepped by the controller. A channel 15 transaction closes the frame and runs
// on through the frame states to a commit state, which waits for the output
// register to be free before the result transaction is loaded into it; the next
// sample is accepted while that result waits. chord_offset sits at address 0 of
// the APB port and may be written only while no transaction is in progress.
module cv_pot_conditioner #(
    parameter int NUM_CHORDS = cvp_pkg::NUM_CHORDS_DFLT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_channel,
    input  logic [15:0]        s_sample,
    input  logic               s_note_unpatched,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_structure,
    output logic [16:0]        m_brightness,
    output logic [16:0]        m_damping,
    output logic [16:0]        m_position,
    output logic signed [22:0] m_fm_amount,
    output logic [21:0]        m_note,
    output logic [22:0]        m_tonic,
    output logic [3:0]         m_chord
);
    import cvp_pkg::*;

    localparam logic REG_CHORD_OFFSET = 1'b0;

    logic [16:0] chord_offset_reg;
    cmd_t        cmd;
    sts_t        sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CHORD_OFFSET) ? {15'b0, chord_offset_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chord_offset_reg <= CHORD_OFFSET_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_CHORD_OFFSET)) begin
            chord_offset_reg <= pwdata[16:0];
        end
    end

    cvp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cvp_datapath #(
        .NUM_CHORDS (NUM_CHORDS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .chord_offset     (chord_offset_reg),
        .s_channel        (s_channel),
        .s_sample         (s_sample),
        .s_note_unpatched (s_note_unpatched),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_structure      (m_structure),
        .m_brightness     (m_brightness),
        .m_damping        (m_damping),
        .m_position       (m_position),
        .m_fm_amount      (m_fm_amount),
        .m_note           (m_note),
        .m_tonic          (m_tonic),
        .m_chord          (m_chord)
    );

endmodule

// ----- rtl/cvp_ctrl.sv -----
module cvp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cvp_pkg::sts_t sts,
    output cvp_pkg::cmd_t cmd
);
    import cvp_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LAW1 = 4'd1;
    localparam logic [3:0] ST_LAW2 = 4'd2;
    localparam logic [3:0] ST_LAW3 = 4'd3;
    localparam logic [3:0] ST_LAW4 = 4'd4;
    localparam logic [3:0] ST_FLT1 = 4'd5;
    localparam logic [3:0] ST_FLT2 = 4'd6;
    localparam logic [3:0] ST_FRM1 = 4'd7;
    localparam logic [3:0] ST_FRM2 = 4'd8;
    localparam logic [3:0] ST_FRM3 = 4'd9;
    localparam logic [3:0] ST_FRM4 = 4'd10;
    localparam logic [3:0] ST_CMT  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LAW1;
                end
            end
            ST_LAW1: begin cmd.law1 = 1'b1; state_next = ST_LAW2; end
            ST_LAW2: begin cmd.law2 = 1'b1; state_next = ST_LAW3; end
            ST_LAW3: begin cmd.law3 = 1'b1; state_next = ST_LAW4; end
            ST_LAW4: begin cmd.law4 = 1'b1; state_next = ST_FLT1; end
            ST_FLT1: begin cmd.filt1 = 1'b1; state_next = ST_FLT2; end
            ST_FLT2: begin
                cmd.filt2  = 1'b1;
                state_next = sts.last ? ST_FRM1 : ST_IDLE;
            end
            ST_FRM1: begin cmd.frm1 = 1'b1; state_next = ST_FRM2; end
            ST_FRM2: begin cmd.frm2 = 1'b1; state_next = ST_FRM3; end
            ST_FRM3: begin cmd.frm3 = 1'b1; state_next = ST_FRM4; end
            ST_FRM4: begin cmd.frm4 = 1'b1; state_next = ST_CMT; end
            ST_CMT: begin
                // hold until the output register can take the transaction
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/cvp_datapath.sv -----
module cvp_datapath #(
    parameter int NUM_CHORDS = cvp_pkg::NUM_CHORDS_DFLT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cvp_pkg::cmd_t      cmd,
    output cvp_pkg::sts_t      sts,
    input  logic [16:0]        chord_offset,
    input  logic [3:0]         s_channel,
    input  logic [15:0]        s_sample,
    input  logic               s_note_unpatched,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_structure,
    output logic [16:0]        m_brightness,
    output logic [16:0]        m_damping,
    output logic [16:0]        m_position,
    output logic signed [22:0] m_fm_amount,
    output logic [21:0]        m_note,
    output logic [22:0]        m_tonic,
    output logic [3:0]         m_chord
);
    import cvp_pkg::*;

    localparam logic [3:0] CHORD_MAX = 4'(NUM_CHORDS - 1);

    // item registers
    logic [3:0]  ch_reg;
    logic [15:0] sample_reg;
    logic        unp_reg;

    // law pipeline
    logic [30:0] sq_reg;
    logic [32:0] p_reg;
    logic [21:0] n_reg;
    logic signed [LP_W-1:0] target_reg;

    // filter
    logic signed [LP_W-1:0] lp_reg [NUM_CH];
    logic [LP_W-1:0] dq_reg;
    logic            dneg_reg;

    // frame state
    logic signed [22:0] tracker_reg;
    logic [7:0]         transpose_reg;
    logic [4:0]         chord_held_reg;

    // frame pipeline
    logic signed [23:0] e_reg;
    logic [21:0]        fm_reg;
    logic [21:0]        t_reg;
    logic signed [37:0] cp_reg;
    logic signed [36:0] ap_reg [4];
    logic [16:0]        att_reg [4];
    logic [10:0]        eq_reg;
    logic               eneg_reg;
    logic               jump_reg;
    logic signed [22:0] c2_reg;
    logic [10:0]        mt_reg;
    logic signed [27:0] c_reg;
    logic signed [42:0] fp_reg;
    logic [10:0]        mc_reg;
    logic               cpos_reg;
    logic               m_valid_reg;

    // law terms
    logic        quartic;
    logic        lawed;
    logic        xneg;
    logic [15:0] xm;
    logic [31:0] sq_full;
    logic [16:0] v2;
    logic [33:0] v2sq;
    logic [39:0] ps;
    logic [44:0] rprod;
    logic [17:0] r;
    logic signed [LP_W-1:0] r_s;

    // filter terms
    logic signed [LP_W-1:0] lp_cur;
    logic signed [LP_W:0]   diff;
    logic [LP_W:0]          dabs;
    logic [48:0]            dprod;

    // frame terms
    logic [15:0]        f0, f1, f5, f6, f7;
    logic [21:0]        fm;
    logic [21:0]        t;
    logic signed [17:0] cd;
    logic [23:0]        eabs;
    logic [41:0]        eprod;
    logic signed [37:0] cpr;
    logic               tgt;
    logic [26:0]        nt;
    logic [21:0]        tmul;
    logic               cgt;
    logic signed [31:0] nc;
    logic signed [42:0] fpr;
    logic signed [26:0] fq;
    logic [21:0]        qmul;
    logic [7:0]         q;
    logic [3:0]         chord_new;
    logic [21:0]        note_v;

    assign sts.last     = (ch_reg == CH_LAST);
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;

    assign quartic = (ch_reg == CH_ATT_FREQ);
    assign lawed   = (ch_reg >= CH_ATT_FIRST);
    assign xneg    = !sample_reg[15];
    assign xm      = sample_reg[15] ? {1'b0, sample_reg[14:0]}
                                    : 16'(17'd32768 - {1'b0, sample_reg});
    assign sq_full = xm * xm;
    assign v2      = sq_reg[30:14];
    assign v2sq    = v2 * v2;
    assign ps      = quartic ? ((40'(p_reg) << 5) + 40'(p_reg))
                             : ((40'(p_reg) << 7) + (40'(p_reg) << 2));
    assign rprod   = n_reg * LAW_RECIP;
    assign r       = rprod[43:26];
    assign r_s     = $signed({2'b00, r});

    assign lp_cur = lp_reg[ch_reg];
    assign diff   = {target_reg[LP_W-1], target_reg} - {lp_cur[LP_W-1], lp_cur};
    assign dabs   = diff[LP_W] ? -diff : diff;
    assign dprod  = dabs[LP_W-1:0] * lp_recip(ch_reg);

    assign f0 = lp_reg[0][15:0];
    assign f1 = lp_reg[1][15:0];
    assign f5 = lp_reg[5][15:0];
    assign f6 = lp_reg[6][15:0];
    assign f7 = lp_reg[7][15:0];

    assign fm    = (22'(f0) << 5) + (22'(f0) << 4);
    assign t     = (22'(f6) << 6) - (22'(f6) << 2);
    assign cd    = $signed({1'b0, chord_offset}) - $signed({2'b00, f1});
    assign eabs  = e_reg[23] ? -e_reg : e_reg;
    assign eprod = eabs[22:0] * FM_RECIP;
    assign cpr   = cp_reg + (cp_reg[37] ? 38'sd65535 : 38'sd0);

    // transpose hysteresis: pull down by 0.3 when rising, up otherwise
    assign tgt  = {2'b00, t_reg} > {transpose_reg, 16'h0000};
    assign nt   = (27'(t_reg) << 3) + (27'(t_reg) << 1)
                + (tgt ? (27'd2 << 16) : (27'd8 << 16));
    assign tmul = mt_reg * TEN_RECIP;

    assign cgt = c_reg > $signed({7'b0, chord_held_reg, 16'h0000});
    assign nc  = (32'(c_reg) <<< 3) + (32'(c_reg) <<< 1)
               + (cgt ? (32'sd4 <<< 16) : (32'sd6 <<< 16));

    assign fpr  = fp_reg + (fp_reg[42] ? 43'sd65535 : 43'sd0);
    assign fq   = fpr[42:16];
    assign qmul = mc_reg * TEN_RECIP;
    assign q    = qmul[21:14];
    assign chord_new = !cpos_reg ? 4'd0
                     : ((q > 8'(CHORD_MAX)) ? CHORD_MAX : q[3:0]);
    assign note_v = (22'(f5) << 6) - (22'(f5) << 2);

    function automatic logic [16:0] atten(input logic signed [36:0] p,
                                          input logic [15:0] pot,
                                          input logic [16:0] hi);
        logic signed [36:0] pr;
        logic signed [21:0] v;
        pr = p + (p[36] ? 37'sd65535 : 37'sd0);
        v  = 22'($signed(pr[36:16])) + $signed({6'b0, pot});
        if (v < 0)
            return 17'd0;
        else if (v > $signed({5'b0, hi}))
            return hi;
        else
            return v[16:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg     <= s_channel;
            sample_reg <= s_sample;
            unp_reg    <= s_note_unpatched;
        end
        if (cmd.law1)
            sq_reg <= sq_full[30:0];
        if (cmd.law2)
            p_reg <= quartic ? v2sq[32:0] : {2'b00, sq_reg};
        if (cmd.law3)
            n_reg <= ps[37:16];
        if (cmd.law4) begin
            if (!lawed)
                target_reg <= $signed({4'b0, sample_reg});
            else
                target_reg <= xneg ? -r_s : r_s;
        end
        if (cmd.filt1) begin
            dneg_reg <= diff[LP_W];
            dq_reg   <= lp_unity(ch_reg) ? dabs[LP_W-1:0] : LP_W'(dprod[48:32]);
        end
        if (cmd.frm1) begin
            fm_reg <= fm;
            e_reg  <= $signed({2'b00, fm}) - $signed({tracker_reg[22], tracker_reg});
            t_reg  <= t;
            cp_reg <= 38'(cd) * 38'(lp_reg[12]);
            for (int i = 0; i < 4; i++)
                ap_reg[i] <= 37'($signed({1'b0, lp_reg[1+i][15:0]})) * 37'(lp_reg[12+i]);
        end
        if (cmd.frm2) begin
            jump_reg <= eabs[22:0] >= FM_JUMP;
            eneg_reg <= e_reg[23];
            eq_reg   <= eprod[34:24];
            c2_reg   <= 23'($signed(cpr[37:16])) + $signed({7'b0, f7});
            mt_reg   <= nt[26:16];
            att_reg[0] <= atten(ap_reg[0], lp_reg[7][15:0], STRUCT_MAX);
            att_reg[1] <= atten(ap_reg[1], lp_reg[8][15:0], Q_ONE);
            att_reg[2] <= atten(ap_reg[2], lp_reg[9][15:0], Q_ONE);
            att_reg[3] <= atten(ap_reg[3], lp_reg[10][15:0], Q_ONE);
        end
        if (cmd.frm3)
            c_reg <= 28'(c2_reg) * 28'($signed({1'b0, CHORD_MAX}));
        if (cmd.frm4) begin
            fp_reg   <= 43'(tracker_reg) * 43'(lp_reg[11]);
            cpos_reg <= nc > 0;
            mc_reg   <= nc[26:16];
        end
        if (cmd.commit) begin
            m_structure  <= att_reg[0][15:0];
            m_brightness <= att_reg[1];
            m_damping    <= att_reg[2];
            m_position   <= att_reg[3];
            if (fq > FM_LIMIT)
                m_fm_amount <= 23'(FM_LIMIT);
            else if (fq < -FM_LIMIT)
                m_fm_amount <= 23'(-FM_LIMIT);
            else
                m_fm_amount <= fq[22:0];
            m_note  <= unp_reg ? 22'd0 : note_v;
            m_tonic <= unp_reg ? (23'd786432 + 23'(t_reg))
                               : {7'(8'd12 + transpose_reg), 16'h0000};
            m_chord <= chord_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CH; i++)
                lp_reg[i] <= '0;
            tracker_reg    <= '0;
            transpose_reg  <= '0;
            chord_held_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.filt2)
                lp_reg[ch_reg] <= lp_cur + (dneg_reg ? -$signed(dq_reg) : $signed(dq_reg));
            if (cmd.frm3) begin
                // jump on a large step, otherwise slew by a fiftieth
                if (jump_reg)
                    tracker_reg <= $signed({1'b0, fm_reg});
                else
                    tracker_reg <= tracker_reg + (eneg_reg ? -$signed({12'b0, eq_reg})
                                                           : $signed({12'b0, eq_reg}));
                transpose_reg <= tmul[21:14];
            end
            if (cmd.commit) begin
                chord_held_reg <= {1'b0, chord_new};
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import cvp_pkg::*;

    localparam int LIMIT_IDLE = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [2:0] ADDR_CHORD_OFFSET = 3'd0;

    typedef struct packed {
        logic [3:0]  channel;
        logic [15:0] sample;
        logic        note_unpatched;
    } sample_t;

    typedef struct packed {
        logic [15:0]        structure;
        logic [16:0]        brightness;
        logic [16:0]        damping;
        logic [16:0]        position;
        logic signed [22:0] fm_amount;
        logic [21:0]        note;
        logic [22:0]        tonic;
        logic [3:0]         chord;
    } params_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_channel = '0;
    logic [15:0]        s_sample = '0;
    logic               s_note_unpatched = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_structure;
    logic [16:0]        m_brightness;
    logic [16:0]        m_damping;
    logic [16:0]        m_position;
    logic signed [22:0] m_fm_amount;
    logic [21:0]        m_note;
    logic [22:0]        m_tonic;
    logic [3:0]         m_chord;

    cv_pot_conditioner u_dut (.*);

    always #1 aclk = ~aclk;

    // frame conditioning state
    longint lp_val[16];
    longint fm_track, transp_held, chord_idx, chord_zero;

    sample_t pending_samples[$];
    params_t expected_params[$];
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      recv_hold = 1'b0;
    int      hold_count = 0;
    int      fail_count = 0;
    int      quiet_cycles = 0;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint shape_law(int ch, longint v);
        longint x, q, r, v2;
        if (ch < 11) return v;
        x = v - 32768;
        q = x * x;
        if (ch == 11) begin
            v2 = q / 16384;
            r = (v2 * v2 * 33 / 10) / 65536;
        end else begin
            r = (q * 132 / 10) / 65536;
        end
        return x < 0 ? -r : r;
    endfunction

    function automatic longint lp_divisor(int ch);
        case (ch)
            0, 5:    return 1;
            1, 2:    return 10;
            3:       return 20;
            4, 6, 7, 8, 9, 10: return 100;
            default: return 200;
        endcase
    endfunction

    function automatic longint blend(int cv, int pot, int att, longint hi);
        return clip(lp_val[cv] * lp_val[att] / 65536 + lp_val[pot], 0, hi);
    endfunction

    // update one channel; on channel 15 compute the frame's parameters
    function automatic bit condition_sample(sample_t s, output params_t p);
        int ch;
        longint fm, err, t, h, c, q;
        ch = s.channel;
        lp_val[ch] += (shape_law(ch, s.sample) - lp_val[ch]) / lp_divisor(ch);
        if (ch != 15) return 1'b0;
        fm = lp_val[0] * 48;
        err = fm - fm_track;
        if (err >= 52429 || err <= -52429) fm_track = fm;
        else fm_track += err / 50;
        p.fm_amount = 23'(clip(fm_track * lp_val[11] / 65536, -3145728, 3145728));
        t = 60 * lp_val[6];
        h = (t - transp_held * 65536 > 0) ? -3 : 3;
        transp_held = (10 * t + (h + 5) * 65536) / 655360;
        p.note = s.note_unpatched ? 22'd0 : 22'(60 * lp_val[5]);
        p.tonic = s.note_unpatched ? 23'(12 * 65536 + t) : 23'((12 + transp_held) * 65536);
        c = (chord_zero - lp_val[1]) * lp_val[12] / 65536;
        c = (c + lp_val[7]) * (NUM_CHORDS_DFLT - 1);
        h = (c - chord_idx * 65536 > 0) ? -1 : 1;
        q = (10 * c + (h + 5) * 65536) / 655360;
        chord_idx = clip(q, 0, NUM_CHORDS_DFLT - 1);
        p.chord = 4'(chord_idx);
        p.structure = 16'(blend(1, 7, 12, STRUCT_MAX));
        p.brightness = 17'(blend(2, 8, 13, 65536));
        p.damping = 17'(blend(3, 9, 14, 65536));
        p.position = 17'(blend(4, 10, 15, 65536));
        return 1'b1;
    endfunction

    // driver: predict at acceptance, then present the next pending sample
    always @(posedge aclk) begin
        params_t p;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (condition_sample({s_channel, s_sample, s_note_unpatched}, p))
                    expected_params.push_back(p);
            end
            if ((!s_valid || s_ready) && pending_samples.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                {s_channel, s_sample, s_note_unpatched} <= pending_samples.pop_front();
            end else if (!s_valid || s_ready) begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        params_t e;
        if (aresetn) begin
            // hold off for a fixed stretch once a hold is requested
            if (recv_hold && hold_count < HOLD_CYCLES) begin
                hold_count <= hold_count + 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
            if (m_valid && m_ready) begin
                if (expected_params.size() == 0) begin
                    $error("unexpected result transaction");
                    fail_count++;
                end else begin
                    e = expected_params.pop_front();
                    if (m_structure !== e.structure) begin
                        $error("structure exp %0d got %0d", e.structure, m_structure);
                        fail_count++;
                    end
                    if (m_brightness !== e.brightness) begin
                        $error("brightness exp %0d got %0d", e.brightness, m_brightness);
                        fail_count++;
                    end
                    if (m_damping !== e.damping) begin
                        $error("damping exp %0d got %0d", e.damping, m_damping);
                        fail_count++;
                    end
                    if (m_position !== e.position) begin
                        $error("position exp %0d got %0d", e.position, m_position);
                        fail_count++;
                    end
                    if (m_fm_amount !== e.fm_amount) begin
                        $error("fm_amount exp %0d got %0d", e.fm_amount, m_fm_amount);
                        fail_count++;
                    end
                    if (m_note !== e.note) begin
                        $error("note exp %0d got %0d", e.note, m_note);
                        fail_count++;
                    end
                    if (m_tonic !== e.tonic) begin
                        $error("tonic exp %0d got %0d", e.tonic, m_tonic);
                        fail_count++;
                    end
                    if (m_chord !== e.chord) begin
                        $error("chord exp %0d got %0d", e.chord, m_chord);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= LIMIT_IDLE) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic add_sample(int ch, int smp, bit unp);
        sample_t s;
        s.channel = 4'(ch);
        s.sample = 16'(smp);
        s.note_unpatched = unp;
        pending_samples.push_back(s);
    endtask

    // full frame with random content, occasionally extreme
    task automatic add_frame();
        int smp;
        for (int ch = 0; ch < 16; ch++) begin
            case ($urandom_range(7))
                0:       smp = 0;
                1:       smp = 16'hFFFF;
                default: smp = int'($urandom_range(16'hFFFF));
            endcase
            add_sample(ch, smp, $urandom_range(3) == 0);
        end
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || s_valid || expected_params.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_chord_offset(logic [16:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_CHORD_OFFSET;
        pwdata <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        chord_zero = longint'(v);
    endtask

    task automatic random_phase(int frames);
        for (int f = 0; f < frames; f++) begin
            if ($urandom_range(9) == 0)
                add_sample(int'($urandom_range(15)), int'($urandom_range(16'hFFFF)),
                           1'($urandom_range(1)));
            else
                add_frame();
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) lp_val[i] = 0;
        fm_track = 0;
        transp_held = 0;
        chord_idx = 0;
        chord_zero = longint'(CHORD_OFFSET_RST);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, full swing then rest, unpatched and patched
        for (int ch = 0; ch < 16; ch++) add_sample(ch, 16'hFFFF, 1'b0);
        add_sample(15, 16'h0000, 1'b1);
        add_sample(11, 16'h0000, 1'b0);
        add_sample(15, 16'h8000, 1'b0);
        add_sample(0, 16'h0000, 1'b0);
        add_sample(15, 16'h7FFF, 1'b1);
        drain();

        write_chord_offset(17'd0);
        send_idle_pct = 22;
        recv_idle_pct = 77;
        random_phase(20);
        drain();

        write_chord_offset(17'd65536);
        send_idle_pct = 77;
        recv_idle_pct = 22;
        random_phase(20);
        drain();

        // hold the receiver off so the block backs up its input
        write_chord_offset(17'($urandom_range(65536)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 1'b1;
        random_phase(20);
        wait (hold_count >= HOLD_CYCLES);
        recv_hold = 1'b0;
        drain();

        write_chord_offset(17'd33095);
        random_phase(11);
        drain();

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
